// File: hdl/rfa_pkg.sv
`timescale 1ns / 1ps

package rfa_pkg;

    localparam int DEF_COS_TABLE_DEPTH = 1024;
    localparam int DEF_FRAC_BITS       = 12;

    // Holds the largest per-coordinate term for any FRAC_BITS from 8 to 16.
    localparam int TERM_W      = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [TERM_W-1:0] term;
        logic              last;
    } rfa_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rfa_qstat_t;

endpackage

// File: hdl/rastrigin_fitness_accumulator_top.sv
`timescale 1ns / 1ps

// Rastrigin fitness accumulator. Each transaction on the coord channel carries one signed
// fixed-point coordinate and a last flag; the block adds x*x + 10 - 10*cos(2*pi*x) to an
// unsigned saturating Q20.12 sum and, on the coordinate marked last, delivers one result
// transaction with the fitness and an overflow flag, then clears the sum. One coordinate is
// taken every clock cycle while coord_stall is low. The last coordinate of a vector passes
// through the first front stage, which registers the cosine ROM read and the square, the
// second, which registers the term, the queue, and the accumulator's output register, from
// which its result is offered. A stall on the result side is absorbed by the four-entry queue
// and the two front stages, six transactions in all, before the coord channel stalls. The
// cosine ROM is a constant table and needs no initialisation after reset.
module rastrigin_fitness_accumulator_top
    import rfa_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = DEF_COS_TABLE_DEPTH,
    parameter int FRAC_BITS       = DEF_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [15:0] coord,
    input  logic               last,
    input  logic               coord_valid,
    output logic               coord_stall,
    output logic [31:0]        fitness,
    output logic               overflowed,
    output logic               result_valid,
    input  logic               result_stall
);

    rfa_qstat_t qstat;
    rfa_item_t  push_item;
    rfa_item_t  pop_item;
    logic       push;
    logic       pop;

    rfa_front #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .FRAC_BITS       (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .coord       (coord),
        .last        (last),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .qstat       (qstat),
        .push        (push),
        .push_item   (push_item)
    );

    rfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    rfa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .pop_item     (pop_item),
        .pop          (pop),
        .fitness      (fitness),
        .overflowed   (overflowed),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// File: hdl/rfa_front.sv
`timescale 1ns / 1ps

module rfa_front
    import rfa_pkg::*;
#(
    parameter int COS_TABLE_DEPTH = DEF_COS_TABLE_DEPTH,
    parameter int FRAC_BITS       = DEF_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [15:0] coord,
    input  logic               last,
    input  logic               coord_valid,
    output logic               coord_stall,
    input  rfa_qstat_t         qstat,
    output logic               push,
    output rfa_item_t          push_item
);

    localparam int IDX_W  = $clog2(COS_TABLE_DEPTH);
    localparam int PROD_W = FRAC_BITS + $clog2(COS_TABLE_DEPTH + 1);
    localparam int UP     = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int DN     = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam logic [TERM_W-1:0] RND = (DN > 0) ? TERM_W'(1) << (DN - 1) : '0;

    typedef logic signed [15:0] rom_t [COS_TABLE_DEPTH];

    function automatic logic [63:0] div_fact(input logic [63:0] v, input int k);
        logic [63:0] r;
        case (k)
            1:       r = v / 64'd2;
            2:       r = v / 64'd12;
            3:       r = v / 64'd30;
            4:       r = v / 64'd56;
            5:       r = v / 64'd90;
            6:       r = v / 64'd132;
            7:       r = v / 64'd182;
            8:       r = v / 64'd240;
            9:       r = v / 64'd306;
            10:      r = v / 64'd380;
            11:      r = v / 64'd462;
            12:      r = v / 64'd552;
            default: r = v;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] cos_entry(input int i);
        logic [63:0] t;
        logic [63:0] theta;
        logic [63:0] term;
        longint      acc;
        logic        neg;
        t   = (64'(i) << 30) / 64'(COS_TABLE_DEPTH);
        neg = 1'b0;
        if (t >= 64'd536870912)
        begin
            t = 64'd1073741824 - t;
        end
        if (t > 64'd268435456)
        begin
            t   = 64'd536870912 - t;
            neg = 1'b1;
        end
        theta = (t * 64'd6746518852) >> 30;
        term  = 64'd1073741824;
        acc   = 64'sd1073741824;
        for (int k = 1; k <= 12; k++)
        begin
            term = (term * theta) >> 30;
            term = (term * theta) >> 30;
            term = div_fact(term, k);
            if (k[0])
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        acc = (acc + 64'sd32768) >>> 16;
        return neg ? 16'(-acc) : 16'(acc);
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < COS_TABLE_DEPTH; i++)
        begin
            r[i] = cos_entry(i);
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic                    advance;
    logic [16:0]             mag;
    logic [33:0]             mag_sq;
    logic [PROD_W-1:0]       idx_prod;
    logic [IDX_W-1:0]        idx;

    logic                    s1_valid_reg;
    logic                    s1_last_reg;
    logic signed [15:0]      s1_cos_reg;
    logic [30:0]             s1_prod_reg;

    logic                    s2_valid_reg;
    rfa_item_t               s2_item_reg;
    rfa_item_t               s2_item_next;

    logic signed [16:0]      diff;
    logic [19:0]             v14;
    logic [TERM_W-1:0]       cos_term;
    logic [TERM_W-1:0]       sq_term;

    assign advance     = !s2_valid_reg || !qstat.full;
    assign coord_stall = !advance;
    assign push        = s2_valid_reg && !qstat.full;
    assign push_item   = s2_item_reg;

    assign mag      = coord[15] ? (17'h10000 - {1'b0, coord}) : {1'b0, coord};
    assign mag_sq   = 34'(mag) * 34'(mag);
    assign idx_prod = PROD_W'(coord[FRAC_BITS-1:0]) * PROD_W'(COS_TABLE_DEPTH);
    assign idx      = idx_prod[FRAC_BITS +: IDX_W];

    always_comb
    begin
        diff    = 17'sd16384 - 17'(s1_cos_reg);
        v14     = 20'(unsigned'(diff)) * 20'd10;
        sq_term = TERM_W'(s1_prod_reg >> FRAC_BITS);
        if (FRAC_BITS >= 14)
        begin
            cos_term = TERM_W'(v14) << UP;
        end
        else
        begin
            cos_term = (TERM_W'(v14) + RND) >> DN;
        end
        s2_item_next.term = sq_term + cos_term;
        s2_item_next.last = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= coord_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cos_reg  <= COS_ROM[idx];
            s1_prod_reg <= mag_sq[30:0];
            s1_last_reg <= last;
            s2_item_reg <= s2_item_next;
        end
    end

endmodule

// File: hdl/rfa_queue.sv
`timescale 1ns / 1ps

module rfa_queue
    import rfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rfa_item_t  push_item,
    input  logic       pop,
    output rfa_item_t  pop_item,
    output rfa_qstat_t qstat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    rfa_item_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign qstat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/rfa_back.sv
`timescale 1ns / 1ps

module rfa_back
    import rfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rfa_qstat_t  qstat,
    input  rfa_item_t   pop_item,
    output logic        pop,
    output logic [31:0] fitness,
    output logic        overflowed,
    output logic        result_valid,
    input  logic        result_stall
);

    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic        sat_reg;
    logic        sat_next;
    logic        out_valid_reg;
    logic [31:0] out_fitness_reg;
    logic        out_over_reg;
    logic [32:0] sum_wide;
    logic        out_free;

    assign out_free     = !out_valid_reg || !result_stall;
    assign pop          = !qstat.empty && out_free;
    assign result_valid = out_valid_reg;
    assign fitness      = out_fitness_reg;
    assign overflowed   = out_over_reg;

    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + 33'(pop_item.term);
        sum_next = sum_wide[32] ? SUM_MAX : sum_wide[31:0];
        sat_next = sat_reg || sum_wide[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (pop_item.last)
                begin
                    sum_reg       <= '0;
                    sat_reg       <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    sum_reg       <= sum_next;
                    sat_reg       <= sat_next;
                    out_valid_reg <= out_valid_reg && result_stall;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_item.last)
        begin
            out_fitness_reg <= sum_next;
            out_over_reg    <= sat_next;
        end
    end

endmodule

// File: hdl/rfa_checker.sv
`timescale 1ns / 1ps

module rfa_checker
    import rfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        last,
    input logic        coord_valid,
    input logic        coord_stall,
    input logic [31:0] fitness,
    input logic        overflowed,
    input logic        result_valid,
    input logic        result_stall
);

    // Vectors whose last coordinate has been taken but whose result is not yet delivered.
    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       last_taken;
    logic       result_taken;

    assign last_taken   = coord_valid && !coord_stall && last;
    assign result_taken = result_valid && !result_stall;

    always_comb
    begin
        pending_next = pending_reg;
        if (last_taken && !result_taken)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (result_taken && !last_taken)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(fitness) && $stable(overflowed))
        else $error("stalled result changed or was withdrawn");

    a_overflow_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && overflowed |-> fitness == SUM_MAX)
        else $error("overflow flagged without a saturated fitness");

    a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 4'd0)
        else $error("result shown with no completed vector outstanding");

endmodule

bind rastrigin_fitness_accumulator_top rfa_checker u_rfa_checker (.*);
